/* rtl/piaw_pkg.sv */
package piaw_pkg;

  localparam int SUM_WIDTH_DEF = 40;
  localparam int FRAC_BITS_DEF = 8;

  localparam int MEAS_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 10;
  localparam int ERR_W   = 17;
  localparam int ACC_W   = 64;  // saturating working width
  localparam int WIDE_W  = 82;  // room for the split excess product
  localparam int MUL_A_W = 33;
  localparam int PROD_W  = 50;
  localparam int HALF_W  = 32;
  localparam int PLO_W   = 48;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  localparam logic [DRIVE_W-1:0] RST_OUT_MAX = 10'd400;
  localparam logic [DRIVE_W-1:0] RST_OUT_MIN = 10'd0;
  localparam int RST_KP_UNITS = 10;
  localparam int RST_KI_UNITS = 1;
  localparam int RST_KC_DIV   = 10;

  typedef enum logic [IDX_W-1:0] {
    REG_REFERENCE  = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_AW    = 3'd3,
    REG_OUTPUT_MAX = 3'd4,
    REG_OUTPUT_MIN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [MEAS_W-1:0] reference;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kc;
    logic [DRIVE_W-1:0]       out_max;
    logic [DRIVE_W-1:0]       out_min;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PK,
    ST_PI,
    ST_CLAMP,
    ST_LO,
    ST_HI,
    ST_CORR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_KP,
    MUL_KI,
    MUL_LO,
    MUL_HI
  } mul_op_t;

  typedef struct packed {
    logic    ld_err;
    logic    mul_en;
    mul_op_t mul_op;
    logic    ld_u;
    logic    ld_clamp;
    logic    ld_plo;
    logic    ld_corr;
    logic    commit;
  } cmd_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] x);
    logic [WIDE_W-ACC_W:0] top;
    top = x[WIDE_W-1:ACC_W-1];
    if (top == '0 || top == '1) begin
      return x[ACC_W-1:0];
    end else if (x[WIDE_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext_acc(input logic signed [ACC_W-1:0] x);
    return {{(WIDE_W-ACC_W){x[ACC_W-1]}}, x};
  endfunction

endpackage

/* rtl/piaw_ifs.sv */
interface piaw_meas_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [piaw_pkg::MEAS_W-1:0]   measured;
  modport source (output valid, output measured, input ready);
  modport sink (input valid, input measured, output ready);
endinterface

interface piaw_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [piaw_pkg::DRIVE_W-1:0]         drive;
  logic signed [piaw_pkg::ERR_W-1:0]    error_value;
  logic                                 clamped;
  modport source (output valid, output drive, output error_value, output clamped, input ready);
  modport sink (input valid, input drive, input error_value, input clamped, output ready);
endinterface

/* rtl/piaw_regs.sv */
module piaw_regs #(
  parameter int FRAC_BITS = piaw_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [piaw_pkg::ADDR_W-1:0]   paddr,
  input  logic [piaw_pkg::DATA_W-1:0]   pwdata,
  output logic [piaw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output piaw_pkg::cfg_t                cfg
);

  localparam logic [piaw_pkg::GAIN_W-1:0] RST_KP =
    piaw_pkg::GAIN_W'(piaw_pkg::RST_KP_UNITS << FRAC_BITS);
  localparam logic [piaw_pkg::GAIN_W-1:0] RST_KI =
    piaw_pkg::GAIN_W'(piaw_pkg::RST_KI_UNITS << FRAC_BITS);
  // 0.1 in Q.F, rounded to nearest
  localparam logic [piaw_pkg::GAIN_W-1:0] RST_KC =
    piaw_pkg::GAIN_W'(((1 << FRAC_BITS) + piaw_pkg::RST_KC_DIV / 2) / piaw_pkg::RST_KC_DIV);

  logic [piaw_pkg::IDX_W-1:0] idx;
  logic                       wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[piaw_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reference <= '0;
      cfg.kp        <= RST_KP;
      cfg.ki        <= RST_KI;
      cfg.kc        <= RST_KC;
      cfg.out_max   <= piaw_pkg::RST_OUT_MAX;
      cfg.out_min   <= piaw_pkg::RST_OUT_MIN;
    end else if (wr) begin
      unique case (idx)
        piaw_pkg::REG_REFERENCE:  cfg.reference <= pwdata[piaw_pkg::MEAS_W-1:0];
        piaw_pkg::REG_GAIN_P:     cfg.kp        <= pwdata[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_GAIN_I:     cfg.ki        <= pwdata[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_GAIN_AW:    cfg.kc        <= pwdata[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_OUTPUT_MAX: cfg.out_max   <= pwdata[piaw_pkg::DRIVE_W-1:0];
        piaw_pkg::REG_OUTPUT_MIN: cfg.out_min   <= pwdata[piaw_pkg::DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      piaw_pkg::REG_REFERENCE:  prdata = piaw_pkg::DATA_W'(unsigned'(cfg.reference));
      piaw_pkg::REG_GAIN_P:     prdata = piaw_pkg::DATA_W'(cfg.kp);
      piaw_pkg::REG_GAIN_I:     prdata = piaw_pkg::DATA_W'(cfg.ki);
      piaw_pkg::REG_GAIN_AW:    prdata = piaw_pkg::DATA_W'(cfg.kc);
      piaw_pkg::REG_OUTPUT_MAX: prdata = piaw_pkg::DATA_W'(cfg.out_max);
      piaw_pkg::REG_OUTPUT_MIN: prdata = piaw_pkg::DATA_W'(cfg.out_min);
      default:                  prdata = '0;
    endcase
  end

endmodule

/* rtl/piaw_ctrl.sv */
module piaw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output piaw_pkg::cmd_t cmd
);

  piaw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= piaw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      piaw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_err = 1'b1;
          state_next = piaw_pkg::ST_PK;
        end
      end
      piaw_pkg::ST_PK: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = piaw_pkg::MUL_KP;
        state_next = piaw_pkg::ST_PI;
      end
      piaw_pkg::ST_PI: begin
        cmd.ld_u   = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = piaw_pkg::MUL_KI;
        state_next = piaw_pkg::ST_CLAMP;
      end
      piaw_pkg::ST_CLAMP: begin
        cmd.ld_clamp = 1'b1;
        state_next   = piaw_pkg::ST_LO;
      end
      piaw_pkg::ST_LO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = piaw_pkg::MUL_LO;
        state_next = piaw_pkg::ST_HI;
      end
      piaw_pkg::ST_HI: begin
        cmd.ld_plo = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = piaw_pkg::MUL_HI;
        state_next = piaw_pkg::ST_CORR;
      end
      piaw_pkg::ST_CORR: begin
        cmd.ld_corr = 1'b1;
        state_next  = piaw_pkg::ST_DONE;
      end
      piaw_pkg::ST_DONE: begin
        // integrator and result register update together, once
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = piaw_pkg::ST_IDLE;
        end
      end
      default: state_next = piaw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == piaw_pkg::ST_PK))
    else $error("accepted beat did not start the step sequence");

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == piaw_pkg::ST_DONE))
    else $error("result valid rose outside of the done state");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit would overwrite an untaken result");

  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (out_valid && state == piaw_pkg::ST_IDLE))
    else $error("commit did not present a result");
`endif

endmodule

/* rtl/piaw_dpath.sv */
module piaw_dpath #(
  parameter int SUM_WIDTH = piaw_pkg::SUM_WIDTH_DEF,
  parameter int FRAC_BITS = piaw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  piaw_pkg::cfg_t                      cfg,
  input  piaw_pkg::cmd_t                      cmd,
  input  logic signed [piaw_pkg::MEAS_W-1:0]  measured,
  output logic [piaw_pkg::DRIVE_W-1:0]        drive,
  output logic signed [piaw_pkg::ERR_W-1:0]   error_value,
  output logic                                clamped
);

  localparam int SH     = 2 * FRAC_BITS;
  localparam int ACC_W  = piaw_pkg::ACC_W;
  localparam int WIDE_W = piaw_pkg::WIDE_W;
  localparam int ERR_W  = piaw_pkg::ERR_W;
  localparam int PROD_W = piaw_pkg::PROD_W;
  localparam int HALF_W = piaw_pkg::HALF_W;
  localparam int PLO_W  = piaw_pkg::PLO_W;
  localparam int DRV_W  = piaw_pkg::DRIVE_W;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic signed [ERR_W-1:0]      err;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      u, exc, ns_acc, corr;
  logic [PLO_W-1:0]             plo;
  logic [DRV_W-1:0]             drive_c;
  logic                         clamped_c;
  logic signed [SUM_WIDTH-1:0]  sum;

  logic signed [ERR_W-1:0]      err_next;
  logic signed [piaw_pkg::MUL_A_W-1:0] mul_a;
  logic [piaw_pkg::GAIN_W-1:0]  mul_b;
  logic signed [piaw_pkg::GAIN_W:0] mul_bx;
  logic signed [PROD_W-1:0]     prod_next;
  logic signed [WIDE_W-1:0]     sum_x, prod_x;
  logic signed [ACC_W-1:0]      sum_plus_prod;
  logic signed [ACC_W-1:0]      hi_fx, lo_fx, uc;
  logic                         u_gt, u_lt;
  logic [DRV_W-1:0]             drive_sel;
  logic signed [ACC_W-1:0]      exc_next;
  logic signed [WIDE_W-1:0]     full;
  logic signed [ACC_W-1:0]      corr_sat;
  logic signed [ACC_W-1:0]      fin;
  logic [ACC_W-SUM_WIDTH:0]     fin_top;
  logic signed [SUM_WIDTH-1:0]  sum_next;

  assign err_next = $signed({cfg.reference[piaw_pkg::MEAS_W-1], cfg.reference})
                  - $signed({measured[piaw_pkg::MEAS_W-1], measured});

  // shared multiplier: signed 33 x unsigned 16
  always_comb begin
    case (cmd.mul_op)
      piaw_pkg::MUL_KP: begin
        mul_a = {{(piaw_pkg::MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = cfg.kp;
      end
      piaw_pkg::MUL_KI: begin
        mul_a = {{(piaw_pkg::MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = cfg.ki;
      end
      piaw_pkg::MUL_LO: begin
        mul_a = {1'b0, exc[HALF_W-1:0]};
        mul_b = cfg.kc;
      end
      piaw_pkg::MUL_HI: begin
        mul_a = {exc[ACC_W-1], exc[ACC_W-1:HALF_W]};
        mul_b = cfg.kc;
      end
      default: begin
        mul_a = {{(piaw_pkg::MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = cfg.kp;
      end
    endcase
  end

  assign mul_bx    = {1'b0, mul_b};
  assign prod_next = mul_a * mul_bx;

  assign sum_x  = {{(WIDE_W-SUM_WIDTH){sum[SUM_WIDTH-1]}}, sum};
  assign prod_x = {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};
  // raw output when prod holds Kp*err, integrator step when it holds Ki*err
  assign sum_plus_prod = piaw_pkg::sat_acc(sum_x + prod_x);

  assign hi_fx = {{(ACC_W-DRV_W-SH){1'b0}}, cfg.out_max, {SH{1'b0}}};
  assign lo_fx = {{(ACC_W-DRV_W-SH){1'b0}}, cfg.out_min, {SH{1'b0}}};
  assign u_gt  = u > hi_fx;
  assign u_lt  = u < lo_fx;

  always_comb begin
    if (u_gt) begin
      uc        = hi_fx;
      drive_sel = cfg.out_max;
    end else if (u_lt) begin
      uc        = lo_fx;
      drive_sel = cfg.out_min;
    end else begin
      uc        = u;
      drive_sel = u[SH +: DRV_W];
    end
  end

  assign exc_next = piaw_pkg::sat_acc(piaw_pkg::ext_acc(u) - piaw_pkg::ext_acc(uc));

  // excess*Kc rebuilt from its two 32-bit halves
  assign full     = $signed({prod, {HALF_W{1'b0}}})
                  + $signed({{(WIDE_W-PLO_W){1'b0}}, plo});
  assign corr_sat = piaw_pkg::sat_acc(full);

  assign fin     = piaw_pkg::sat_acc(piaw_pkg::ext_acc(ns_acc) - piaw_pkg::ext_acc(corr));
  assign fin_top = fin[ACC_W-1:SUM_WIDTH-1];

  always_comb begin
    if (fin_top == '0 || fin_top == '1) begin
      sum_next = fin[SUM_WIDTH-1:0];
    end else if (fin[ACC_W-1]) begin
      sum_next = SUM_MIN;
    end else begin
      sum_next = SUM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_err) begin
      err <= err_next;
    end
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.ld_u) begin
      u <= sum_plus_prod;
    end
    if (cmd.ld_clamp) begin
      exc       <= exc_next;
      ns_acc    <= sum_plus_prod;
      drive_c   <= drive_sel;
      clamped_c <= u_gt | u_lt;
    end
    if (cmd.ld_plo) begin
      plo <= prod[PLO_W-1:0];
    end
    if (cmd.ld_corr) begin
      corr <= corr_sat >>> FRAC_BITS;
    end
    if (cmd.commit) begin
      drive       <= drive_c;
      error_value <= err;
      clamped     <= clamped_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (cmd.commit) begin
      sum <= sum_next;
    end
  end

endmodule

/* rtl/pi_controller_antiwindup.sv */
// PI controller with back-calculation anti-windup, fixed point.
// Each accepted input beat runs the states PK, PI, CLAMP, LO, HI, CORR and DONE,
// DONE waiting while a result is untaken; no new beat is taken until it commits.
// One 33x17 multiplier, stepped by the controller, is shared by the Kp, Ki and the two halves of the Kc products.
// Reset (rst, synchronous): integral sum cleared, registers to their defaults,
// no result pending.
module pi_controller_antiwindup #(
  parameter int SUM_WIDTH = piaw_pkg::SUM_WIDTH_DEF,
  parameter int FRAC_BITS = piaw_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [piaw_pkg::ADDR_W-1:0]   paddr,
  input  logic [piaw_pkg::DATA_W-1:0]   pwdata,
  output logic [piaw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  piaw_meas_if.sink                     meas,
  piaw_result_if.source                 result
);

  piaw_pkg::cfg_t cfg;
  piaw_pkg::cmd_t cmd;

  piaw_regs #(
    .FRAC_BITS(FRAC_BITS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  piaw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (meas.valid),
    .in_ready  (meas.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  piaw_dpath #(
    .SUM_WIDTH(SUM_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .measured    (meas.measured),
    .drive       (result.drive),
    .error_value (result.error_value),
    .clamped     (result.clamped)
  );

endmodule
